// File: hdl/assert_macros.svh
// Assertion macros used by the top level of the GOST block cipher unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk_i and disabled during reset.
`define GBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and disabled during reset.
`define GBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/gbc_pkg.sv
// Package with the types, constants and round functions of the GOST block cipher unit.
`default_nettype none

package gbc_pkg;

  localparam int unsigned NUM_ROUNDS = 32;
  localparam int unsigned NUM_KEYS   = 8;
  localparam int unsigned ROT_LEFT   = 11;
  localparam int unsigned ROT_RIGHT  = 21;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned ROUND_W    = 5;
  localparam int unsigned KEY_IDX_W  = 3;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        command;
    logic [31:0] left_half;
    logic [31:0] right_half;
  } in_item_t;

  typedef struct packed {
    logic [31:0] left_out;
    logic [31:0] right_out;
  } out_item_t;

  typedef struct packed {
    logic        command;
    logic [31:0] word_a;
    logic [31:0] word_b;
  } stage_t;

  localparam logic [3:0] SBOX [NUM_KEYS][16] = '{
    '{4'h4, 4'ha, 4'h9, 4'h2, 4'hd, 4'h8, 4'h0, 4'he,
      4'h6, 4'hb, 4'h1, 4'hc, 4'h7, 4'hf, 4'h5, 4'h3},
    '{4'he, 4'hb, 4'h4, 4'hc, 4'h6, 4'hd, 4'hf, 4'ha,
      4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
    '{4'h5, 4'h8, 4'h1, 4'hd, 4'ha, 4'h3, 4'h4, 4'h2,
      4'he, 4'hf, 4'hc, 4'h7, 4'h6, 4'h0, 4'h9, 4'hb},
    '{4'h7, 4'hd, 4'ha, 4'h1, 4'h0, 4'h8, 4'h9, 4'hf,
      4'he, 4'h4, 4'h6, 4'hc, 4'hb, 4'h2, 4'h5, 4'h3},
    '{4'h6, 4'hc, 4'h7, 4'h1, 4'h5, 4'hf, 4'hd, 4'h8,
      4'h4, 4'ha, 4'h9, 4'he, 4'h0, 4'h3, 4'hb, 4'h2},
    '{4'h4, 4'hb, 4'ha, 4'h0, 4'h7, 4'h2, 4'h1, 4'hd,
      4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hc, 4'hf, 4'he},
    '{4'hd, 4'hb, 4'h4, 4'h1, 4'h3, 4'hf, 4'h5, 4'h9,
      4'h0, 4'ha, 4'he, 4'h7, 4'h6, 4'h8, 4'h2, 4'hc},
    '{4'h1, 4'hf, 4'hd, 4'h0, 4'h5, 4'h7, 4'ha, 4'h4,
      4'h9, 4'h2, 4'h3, 4'he, 4'h6, 4'hb, 4'h8, 4'hc}
  };

  // Substitutes each nibble through its own S-box and rotates the word left.
  function automatic logic [31:0] round_func(input logic [31:0] v);
    logic [31:0] s;
    s = '0;
    for (int n = 0; n < NUM_KEYS; n++) begin
      s[4*n +: 4] = SBOX[n][v[4*n +: 4]];
    end
    return (s << ROT_LEFT) | (s >> ROT_RIGHT);
  endfunction

  // Key word used by a round of encryption: three forward passes, then one backward.
  function automatic logic [KEY_IDX_W-1:0] enc_key_index(input logic [ROUND_W-1:0] round);
    return (round < ROUND_W'(24)) ? round[KEY_IDX_W-1:0] : ~round[KEY_IDX_W-1:0];
  endfunction

  // Decryption runs the encryption key schedule in reverse order.
  function automatic logic [KEY_IDX_W-1:0] dec_key_index(input logic [ROUND_W-1:0] round);
    return enc_key_index(~round);
  endfunction

endpackage

`default_nettype wire

// File: hdl/gbc_round_cell.sv
// One Feistel round of the cipher with its own pipeline register and flow control.
`default_nettype none

module gbc_round_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire gbc_pkg::stage_t data_i,
  output logic                ready_o,
  input  wire logic [31:0]    key_i,
  output logic                valid_o,
  output gbc_pkg::stage_t     data_o,
  input  wire logic           ready_i
);

  logic            valid_q;
  gbc_pkg::stage_t data_q;
  gbc_pkg::stage_t data_d;
  logic [31:0]     sum;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    sum            = data_i.word_a + key_i;
    data_d.command = data_i.command;
    data_d.word_a  = data_i.word_b ^ gbc_pkg::round_func(sum);
    data_d.word_b  = data_i.word_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: hdl/gost_block_cipher_64_unit.sv
// Top level of the GOST 28147-89 ECB block cipher unit with key registers and round chain.
`default_nettype none

// Encrypts or decrypts one 64-bit block per transfer with a 256-bit key held in eight
// registers (index 0 to 7; writes to other indexes are ignored). Blocks flow through a
// chain of 32 round cells, one round per cell, and a block's result is held on the outputs
// by the register of the last cell. A new block can be taken every cycle unless every cell
// is full and the output is stalled. The last cell's register is the output register;
// empty cells in the chain keep taking input while a result is stalled. Key registers
// should be written only while no block is in flight.
module gost_block_cipher_64_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire gbc_pkg::in_item_t                 in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output gbc_pkg::out_item_t                     out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gbc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [31:0]                       cfg_data_i
);

`include "assert_macros.svh"

  logic [31:0] key_q [gbc_pkg::NUM_KEYS];

  logic            stage_valid [gbc_pkg::NUM_ROUNDS+1];
  gbc_pkg::stage_t stage_data  [gbc_pkg::NUM_ROUNDS+1];
  logic            stage_ready [gbc_pkg::NUM_ROUNDS+1];
  logic            chain_full;
  logic            last_can_move;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < gbc_pkg::NUM_KEYS; k++) begin
        key_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      for (int k = 0; k < gbc_pkg::NUM_KEYS; k++) begin
        if (cfg_index_i == gbc_pkg::CFG_IDX_W'(k)) begin
          key_q[k] <= cfg_data_i;
        end
      end
    end
  end

  assign stage_valid[0]           = in_valid_i;
  assign stage_data[0].command    = in_data_i.command;
  assign stage_data[0].word_a     = in_data_i.left_half;
  assign stage_data[0].word_b     = in_data_i.right_half;
  assign in_stall_o               = !stage_ready[0];

  for (genvar r = 0; r < gbc_pkg::NUM_ROUNDS; r++) begin : g_round
    localparam logic [gbc_pkg::ROUND_W-1:0] Round = gbc_pkg::ROUND_W'(r);
    localparam logic [gbc_pkg::KEY_IDX_W-1:0] EncIdx = gbc_pkg::enc_key_index(Round);
    localparam logic [gbc_pkg::KEY_IDX_W-1:0] DecIdx = gbc_pkg::dec_key_index(Round);

    logic [31:0] round_key;

    assign round_key = (stage_data[r].command == gbc_pkg::CMD_DECRYPT) ?
                       key_q[DecIdx] : key_q[EncIdx];

    gbc_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[r]),
      .data_i  (stage_data[r]),
      .ready_o (stage_ready[r]),
      .key_i   (round_key),
      .valid_o (stage_valid[r+1]),
      .data_o  (stage_data[r+1]),
      .ready_i (stage_ready[r+1])
    );
  end

  assign stage_ready[gbc_pkg::NUM_ROUNDS] = !out_stall_i;

  // The exchange after the last round is undone on the way out.
  assign out_valid_o          = stage_valid[gbc_pkg::NUM_ROUNDS];
  assign out_data_o.left_out  = stage_data[gbc_pkg::NUM_ROUNDS].word_b;
  assign out_data_o.right_out = stage_data[gbc_pkg::NUM_ROUNDS].word_a;

  always_comb begin
    chain_full = 1'b1;
    for (int r = 1; r <= gbc_pkg::NUM_ROUNDS; r++) begin
      chain_full = chain_full && stage_valid[r];
    end
  end

  assign last_can_move = stage_valid[gbc_pkg::NUM_ROUNDS-1] && !(out_valid_o && out_stall_i);

  `GBC_ASSERT_NEXT(a_accept_fills_first, in_valid_i && !in_stall_o, stage_valid[1], "input lost")
  `GBC_ASSERT_NEXT(a_last_round_moves, last_can_move, out_valid_o, "last round stuck")
  `GBC_ASSERT_NOW(a_stall_only_when_full, in_stall_o, chain_full && out_stall_i, "early stall")

endmodule

`default_nettype wire
